FILE: sv/tkm_pkg.sv
// Shared constants, types and helpers of the trie keyword matcher.
package tkm_pkg;

    // Capacity of the trie
    localparam int MAX_NODES    = 256;
    localparam int MAX_SYMBOLS  = 64;
    localparam int MAX_PATTERNS = 64;

    // Derived widths
    localparam int NODE_W   = $clog2(MAX_NODES);
    localparam int SYM_W    = $clog2(MAX_SYMBOLS);
    localparam int PAT_W    = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int NCNT_W   = $clog2(MAX_NODES + 1);
    localparam int SCNT_W   = $clog2(MAX_SYMBOLS + 1);
    localparam int PCNT_W   = $clog2(MAX_PATTERNS + 1);
    localparam int EDATA_W  = (NODE_W > PAT_W) ? NODE_W : PAT_W;
    localparam int ENTRY_W  = EDATA_W + 2;
    localparam int TABLE_AW = NODE_W + SYM_W;
    localparam int TABLE_DEPTH = 1 << TABLE_AW;

    // Fixed field widths of the item channels
    localparam int KIND_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int CHAR_DEPTH = 1 << CHAR_W;
    localparam int STATUS_W   = 3;
    localparam int PIDX_W     = 6;
    localparam int NCOUNT_W   = 9;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MATCH  = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE          = 3'd0,
        ST_RUNNING       = 3'd1,
        ST_MATCHED       = 3'd2,
        ST_REJECTED      = 3'd3,
        ST_TABLE_FULL    = 3'd4,
        ST_ALPHABET_FULL = 3'd5,
        ST_TOO_MANY      = 3'd6
    } t_status;

    typedef logic [NODE_W-1:0]   t_node;
    typedef logic [SYM_W-1:0]    t_sym;
    typedef logic [CHAR_W-1:0]   t_char;
    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [TABLE_AW-1:0] t_slot;

    // One transition table entry: child node, or accept entry with pattern index
    typedef struct packed {
        logic               valid;
        logic               accept;
        logic [EDATA_W-1:0] data;
    } t_entry;

    // Item as it leaves the symbol lookup stage
    typedef struct packed {
        logic  valid;
        t_kind kind;
        t_char character;
        logic  restart;
        t_sym  sym;
        logic  sym_new;
    } t_stage_item;

    // Symbol map update requested by the trie stage
    typedef struct packed {
        logic  en;
        logic  clear;
        t_char addr;
        t_sym  sym;
    } t_map_wr;

    // Next walk positions, forwarded to the lookup stage
    typedef struct packed {
        t_node cursor;
        t_node match_node;
    } t_node_fwd;

    // Transition table read request
    typedef struct packed {
        logic  re;
        t_slot addr;
    } t_tbl_rd;

    // Result of one item
    typedef struct packed {
        logic                valid;
        t_status             status;
        logic [PIDX_W-1:0]   pattern_index;
        logic [NCOUNT_W-1:0] node_count;
    } t_result;

    function automatic logic [PIDX_W-1:0] to_pidx(input logic [EDATA_W-1:0] d);
        logic [EDATA_W+PIDX_W-1:0] w;
        w = {{PIDX_W{1'b0}}, d};
        return w[PIDX_W-1:0];
    endfunction

    function automatic logic [NCOUNT_W-1:0] to_ncount(input logic [NCNT_W-1:0] n);
        logic [NCNT_W+NCOUNT_W-1:0] w;
        w = {{NCOUNT_W{1'b0}}, n};
        return w[NCOUNT_W-1:0];
    endfunction

endpackage

FILE: sv/tkm_in_if.sv
// Input item channel of the trie keyword matcher.
interface tkm_in_if;
    logic                        valid;
    logic                        ready;
    logic [tkm_pkg::KIND_W-1:0]  kind;
    logic [tkm_pkg::CHAR_W-1:0]  character;
    logic                        restart;

    modport source (output valid, kind, character, restart, input ready);
    modport sink   (input valid, kind, character, restart, output ready);
endinterface

FILE: sv/tkm_out_if.sv
// Result item channel of the trie keyword matcher.
interface tkm_out_if;
    logic                          valid;
    logic                          ready;
    logic [tkm_pkg::STATUS_W-1:0]  status;
    logic [tkm_pkg::PIDX_W-1:0]    pattern_index;
    logic [tkm_pkg::NCOUNT_W-1:0]  node_count;

    modport source (output valid, status, pattern_index, node_count, input ready);
    modport sink   (input valid, status, pattern_index, node_count, output ready);
endinterface

FILE: sv/tkm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tkm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the contents before a write at the same edge
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/tkm_lookup.sv
// Symbol lookup stage: byte to symbol mapping and transition table address.
module tkm_lookup (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_accept,
    input  tkm_pkg::t_kind        i_kind,
    input  tkm_pkg::t_char        i_character,
    input  logic                  i_restart,
    input  tkm_pkg::t_map_wr      i_map_wr,
    input  tkm_pkg::t_node_fwd    i_node_fwd,
    output tkm_pkg::t_stage_item  o_item,
    output tkm_pkg::t_tbl_rd      o_tbl_rd
);

    logic                              r_valid;
    tkm_pkg::t_kind                    r_kind;
    tkm_pkg::t_char                    r_char;
    logic                              r_restart;
    logic                              r_fwd_hit;
    tkm_pkg::t_sym                     r_fwd_sym;
    logic                              r_mvalid;
    logic [tkm_pkg::CHAR_DEPTH-1:0]    r_map_valid;

    tkm_pkg::t_sym map_rdata;
    tkm_pkg::t_sym sym_base;
    tkm_pkg::t_sym sym_eff;
    tkm_pkg::t_node node_sel;

    tkm_ram #(
        .WIDTH (tkm_pkg::SYM_W),
        .DEPTH (tkm_pkg::CHAR_DEPTH)
    ) u_symbol_map (
        .i_clk   (i_clk),
        .i_we    (i_adv && i_map_wr.en),
        .i_waddr (i_map_wr.addr),
        .i_wdata (i_map_wr.sym),
        .i_re    (i_accept),
        .i_raddr (i_character),
        .o_rdata (map_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_map_valid <= '0;
        end else begin
            if (i_adv) begin
                r_valid <= i_accept;
            end
            if (i_adv && i_map_wr.clear) begin
                r_map_valid <= '0;
            end else if (i_adv && i_map_wr.en) begin
                r_map_valid[i_map_wr.addr] <= 1'b1;
            end
        end
    end

    // Capture the item; catch a symbol written at the same edge
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_kind    <= i_kind;
            r_char    <= i_character;
            r_restart <= i_restart;
            r_fwd_hit <= i_map_wr.en && (i_map_wr.addr == i_character);
            r_fwd_sym <= i_map_wr.sym;
            r_mvalid  <= r_map_valid[i_character];
        end
    end

    always_comb begin
        sym_base = r_fwd_hit ? r_fwd_sym : (r_mvalid ? map_rdata : '0);
        // A symbol assigned by the item ahead takes precedence
        if (i_map_wr.en && (i_map_wr.addr == r_char)) begin
            sym_eff = i_map_wr.sym;
        end else begin
            sym_eff = sym_base;
        end

        if (r_kind == tkm_pkg::KIND_MATCH) begin
            node_sel = r_restart ? '0 : i_node_fwd.match_node;
        end else begin
            node_sel = i_node_fwd.cursor;
        end

        o_tbl_rd.re   = i_adv && r_valid;
        o_tbl_rd.addr = {node_sel, sym_eff};

        o_item.valid     = r_valid;
        o_item.kind      = r_kind;
        o_item.character = r_char;
        o_item.restart   = r_restart;
        o_item.sym       = sym_eff;
        o_item.sym_new   = (sym_eff == '0);
    end

endmodule

FILE: sv/tkm_trie.sv
// Trie stage: transition table, build and match state, per-item result.
module tkm_trie (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  tkm_pkg::t_stage_item  i_item,
    input  tkm_pkg::t_tbl_rd      i_tbl_rd,
    output tkm_pkg::t_map_wr      o_map_wr,
    output tkm_pkg::t_node_fwd    o_node_fwd,
    output tkm_pkg::t_result      o_result,
    output logic                  o_busy
);

    tkm_pkg::t_stage_item           r_s2;
    logic [tkm_pkg::NCNT_W-1:0]     r_nodes_used;
    logic [tkm_pkg::SCNT_W-1:0]     r_symbols_used;
    logic [tkm_pkg::PCNT_W-1:0]     r_patterns_done;
    tkm_pkg::t_node                 r_cursor;
    logic                           r_build_error;
    tkm_pkg::t_status               r_error_code;
    tkm_pkg::t_node                 r_match_node;
    logic                           r_match_dead;
    logic                           r_sweep;
    tkm_pkg::t_slot                 r_sweep_addr;
    logic                           r_tfwd_hit;
    tkm_pkg::t_entry                r_tfwd_data;

    logic [tkm_pkg::NCNT_W-1:0]     n_nodes_used;
    logic [tkm_pkg::SCNT_W-1:0]     n_symbols_used;
    logic [tkm_pkg::PCNT_W-1:0]     n_patterns_done;
    tkm_pkg::t_node                 n_cursor;
    logic                           n_build_error;
    tkm_pkg::t_status               n_error_code;
    tkm_pkg::t_node                 n_match_node;
    logic                           n_match_dead;

    logic [tkm_pkg::ENTRY_W-1:0]    tbl_rdata;
    tkm_pkg::t_entry                entry;
    tkm_pkg::t_map_wr               map_wr;
    logic                           tbl_we;
    tkm_pkg::t_slot                 tbl_waddr;
    tkm_pkg::t_entry                tbl_wdata;
    logic                           ram_we;
    tkm_pkg::t_slot                 ram_waddr;
    tkm_pkg::t_entry                ram_wdata;
    tkm_pkg::t_status               status;
    logic [tkm_pkg::PIDX_W-1:0]     pidx;
    tkm_pkg::t_sym                  sym_use;
    logic                           sym_ok;
    logic                           dead_sel;
    logic                           start_sweep;

    tkm_ram #(
        .WIDTH (tkm_pkg::ENTRY_W),
        .DEPTH (tkm_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_tbl_rd.re),
        .i_raddr (i_tbl_rd.addr),
        .o_rdata (tbl_rdata)
    );

    always_comb begin
        entry           = r_tfwd_hit ? r_tfwd_data : tkm_pkg::t_entry'(tbl_rdata);
        n_nodes_used    = r_nodes_used;
        n_symbols_used  = r_symbols_used;
        n_patterns_done = r_patterns_done;
        n_cursor        = r_cursor;
        n_build_error   = r_build_error;
        n_error_code    = r_error_code;
        n_match_node    = r_match_node;
        n_match_dead    = r_match_dead;
        map_wr          = '0;
        tbl_we          = 1'b0;
        tbl_waddr       = '0;
        tbl_wdata       = '0;
        status          = tkm_pkg::ST_DONE;
        pidx            = '0;
        sym_use         = r_s2.sym;
        sym_ok          = 1'b1;
        dead_sel        = r_match_dead;
        start_sweep     = 1'b0;

        if (r_s2.valid) begin
            unique case (r_s2.kind)
                tkm_pkg::KIND_CLEAR: begin
                    n_nodes_used    = tkm_pkg::NCNT_W'(1);
                    n_symbols_used  = tkm_pkg::SCNT_W'(1);
                    n_patterns_done = '0;
                    n_cursor        = '0;
                    n_build_error   = 1'b0;
                    n_error_code    = tkm_pkg::ST_DONE;
                    n_match_node    = '0;
                    n_match_dead    = 1'b0;
                    map_wr.clear    = 1'b1;
                    start_sweep     = 1'b1;
                end
                tkm_pkg::KIND_INSERT: begin
                    if (r_build_error) begin
                        status = r_error_code;
                    end else if (r_s2.character == '0) begin
                        // End of pattern: accept entry on the delimiter edge
                        if (r_patterns_done >= tkm_pkg::PCNT_W'(tkm_pkg::MAX_PATTERNS)) begin
                            n_build_error = 1'b1;
                            n_error_code  = tkm_pkg::ST_TOO_MANY;
                            status        = tkm_pkg::ST_TOO_MANY;
                        end else begin
                            tbl_we           = 1'b1;
                            tbl_waddr        = {r_cursor, tkm_pkg::t_sym'(0)};
                            tbl_wdata.valid  = 1'b1;
                            tbl_wdata.accept = 1'b1;
                            tbl_wdata.data   = tkm_pkg::EDATA_W'(
                                r_patterns_done[tkm_pkg::PAT_W-1:0]);
                            n_patterns_done  = r_patterns_done + tkm_pkg::PCNT_W'(1);
                            n_cursor         = '0;
                        end
                    end else begin
                        // Assign a symbol to a byte seen for the first time
                        if (r_s2.sym_new) begin
                            if (r_symbols_used >= tkm_pkg::SCNT_W'(tkm_pkg::MAX_SYMBOLS)) begin
                                n_build_error = 1'b1;
                                n_error_code  = tkm_pkg::ST_ALPHABET_FULL;
                                status        = tkm_pkg::ST_ALPHABET_FULL;
                                sym_ok        = 1'b0;
                            end else begin
                                sym_use        = r_symbols_used[tkm_pkg::SYM_W-1:0];
                                n_symbols_used = r_symbols_used + tkm_pkg::SCNT_W'(1);
                                map_wr.en      = 1'b1;
                                map_wr.addr    = r_s2.character;
                                map_wr.sym     = sym_use;
                            end
                        end
                        if (sym_ok) begin
                            if (!r_s2.sym_new && entry.valid && !entry.accept) begin
                                n_cursor = entry.data[tkm_pkg::NODE_W-1:0];
                            end else if (r_nodes_used >= tkm_pkg::NCNT_W'(tkm_pkg::MAX_NODES)) begin
                                n_build_error = 1'b1;
                                n_error_code  = tkm_pkg::ST_TABLE_FULL;
                                status        = tkm_pkg::ST_TABLE_FULL;
                            end else begin
                                tbl_we           = 1'b1;
                                tbl_waddr        = {r_cursor, sym_use};
                                tbl_wdata.valid  = 1'b1;
                                tbl_wdata.accept = 1'b0;
                                tbl_wdata.data   = tkm_pkg::EDATA_W'(
                                    r_nodes_used[tkm_pkg::NODE_W-1:0]);
                                n_cursor         = r_nodes_used[tkm_pkg::NODE_W-1:0];
                                n_nodes_used     = r_nodes_used + tkm_pkg::NCNT_W'(1);
                            end
                        end
                    end
                end
                tkm_pkg::KIND_MATCH: begin
                    n_match_node = r_s2.restart ? '0 : r_match_node;
                    dead_sel     = r_s2.restart ? 1'b0 : r_match_dead;
                    n_match_dead = dead_sel;
                    if (dead_sel) begin
                        status = tkm_pkg::ST_REJECTED;
                    end else if (!entry.valid) begin
                        n_match_dead = 1'b1;
                        status       = tkm_pkg::ST_REJECTED;
                    end else if (entry.accept) begin
                        n_match_dead = 1'b1;
                        pidx         = tkm_pkg::to_pidx(entry.data);
                        status       = tkm_pkg::ST_MATCHED;
                    end else begin
                        n_match_node = entry.data[tkm_pkg::NODE_W-1:0];
                        status       = tkm_pkg::ST_RUNNING;
                    end
                end
                default: begin
                end
            endcase
        end

        // Sweep owns the write port; no item is in flight meanwhile
        if (r_sweep) begin
            ram_we    = 1'b1;
            ram_waddr = r_sweep_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = i_adv && tbl_we;
            ram_waddr = tbl_waddr;
            ram_wdata = tbl_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2            <= '0;
            r_nodes_used    <= tkm_pkg::NCNT_W'(1);
            r_symbols_used  <= tkm_pkg::SCNT_W'(1);
            r_patterns_done <= '0;
            r_cursor        <= '0;
            r_build_error   <= 1'b0;
            r_error_code    <= tkm_pkg::ST_DONE;
            r_match_node    <= '0;
            r_match_dead    <= 1'b0;
            r_sweep         <= 1'b1;
            r_sweep_addr    <= '0;
        end else begin
            if (i_adv) begin
                r_s2 <= i_item;
            end
            if (i_adv && r_s2.valid) begin
                r_nodes_used    <= n_nodes_used;
                r_symbols_used  <= n_symbols_used;
                r_patterns_done <= n_patterns_done;
                r_cursor        <= n_cursor;
                r_build_error   <= n_build_error;
                r_error_code    <= n_error_code;
                r_match_node    <= n_match_node;
                r_match_dead    <= n_match_dead;
            end
            if (i_adv && start_sweep) begin
                r_sweep      <= 1'b1;
                r_sweep_addr <= '0;
            end else if (r_sweep) begin
                if (r_sweep_addr == '1) begin
                    r_sweep <= 1'b0;
                end
                r_sweep_addr <= r_sweep_addr + tkm_pkg::TABLE_AW'(1);
            end
        end
    end

    // Catch a table write that lands on the slot being read at the same edge
    always_ff @(posedge i_clk) begin
        if (i_tbl_rd.re) begin
            r_tfwd_hit  <= ram_we && (ram_waddr == i_tbl_rd.addr);
            r_tfwd_data <= ram_wdata;
        end
    end

    assign o_map_wr              = map_wr;
    assign o_node_fwd.cursor     = n_cursor;
    assign o_node_fwd.match_node = n_match_node;

    always_comb begin
        o_result.valid         = r_s2.valid;
        o_result.status        = status;
        o_result.pattern_index = pidx;
        o_result.node_count    = tkm_pkg::to_ncount(n_nodes_used);
    end

    assign o_busy = r_sweep || (r_s2.valid && (r_s2.kind == tkm_pkg::KIND_CLEAR));

endmodule

FILE: sv/trie_keyword_matcher.sv
// Top level of the trie keyword matcher: two-stage pipe plus result register.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-----------------------------------------
//   i_in     | in  | valid/ready        | kind[1:0], character[7:0], restart
//   o_res    | out | valid/ready        | status[2:0], pattern_index[5:0], node_count[8:0]
//
// One item per cycle sustained while o_res does not stall and no clear or sweep holds
// ready low. An accepted item is registered in the symbol lookup stage, then in the
// trie stage, then in the result register, which drives o_res. The trie step is set
// by the transition table read: its registered data feeds the next item's read address.
// After reset a sweep invalidates all 16384 table entries, one per cycle, with ready
// low throughout; a clear item also holds ready low while it is in either stage and
// through the sweep it starts. A stall on o_res holds the whole pipe; i_in is taken
// while a result waits only when the result register frees up in the same cycle.
module trie_keyword_matcher (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tkm_in_if.sink           i_in,
    tkm_out_if.source        o_res
);

    logic                  r_out_valid;
    tkm_pkg::t_result      r_out;

    logic                  adv;
    logic                  accept;
    logic                  busy;
    logic                  clear_in_lookup;
    tkm_pkg::t_stage_item  item;
    tkm_pkg::t_tbl_rd      tbl_rd;
    tkm_pkg::t_map_wr      map_wr;
    tkm_pkg::t_node_fwd    node_fwd;
    tkm_pkg::t_result      result;

    // Advance the pipe whenever the result register is free or being drained
    assign adv             = !r_out_valid || o_res.ready;
    // Hold input while a clear is in flight so nothing reads stale symbols
    assign clear_in_lookup = item.valid && (item.kind == tkm_pkg::KIND_CLEAR);
    assign i_in.ready      = adv && !busy && !clear_in_lookup;
    assign accept          = i_in.valid && i_in.ready;

    tkm_lookup u_lookup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_accept    (accept),
        .i_kind      (i_in.kind),
        .i_character (i_in.character),
        .i_restart   (i_in.restart),
        .i_map_wr    (map_wr),
        .i_node_fwd  (node_fwd),
        .o_item      (item),
        .o_tbl_rd    (tbl_rd)
    );

    tkm_trie u_trie (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_item     (item),
        .i_tbl_rd   (tbl_rd),
        .o_map_wr   (map_wr),
        .o_node_fwd (node_fwd),
        .o_result   (result),
        .o_busy     (busy)
    );

    // Result register: load on advance, drop valid when drained with nothing behind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && result.valid) begin
            r_out <= result;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_out.status;
    assign o_res.pattern_index = r_out.pattern_index;
    assign o_res.node_count    = r_out.node_count;

endmodule

FILE: sim/tb_trie_keyword_matcher.sv
// Self-checking testbench of the trie keyword matcher: trie build and text walk checks.
module tb_trie_keyword_matcher;
    import tkm_pkg::*;

    // Generous ceiling: each clear costs a full table sweep, so the slowest
    // correct run stays well under this
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 20;
    localparam int WORD_SLOTS   = 80;
    localparam int WORD_MAX     = 80;
    localparam int HOLD_CYCLES  = 300;

    // Kind code that the block must ignore
    localparam t_kind KIND_UNUSED = 2'd3;

    typedef struct packed {
        t_status             status;
        logic [PIDX_W-1:0]   pattern_index;
        logic [NCOUNT_W-1:0] node_count;
    } trie_result_t;

    // Shadow copy of the trie; predicts one result per accepted item and
    // checks results in order against it
    class trie_shadow;
        t_sym         sym_of_byte [CHAR_DEPTH];
        t_entry       edge_tab [TABLE_DEPTH];
        int unsigned  nodes_used;
        int unsigned  syms_used;
        int unsigned  pats_done;
        t_node        build_cursor;
        bit           build_failed;
        t_status      build_code;
        t_node        walk_node;
        bit           walk_dead;
        trie_result_t awaited_results[$];
        int           mismatches;
        int           results_seen;

        function new();
            mismatches   = 0;
            results_seen = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (sym_of_byte[i]) sym_of_byte[i] = '0;
            foreach (edge_tab[i]) edge_tab[i] = '0;
            nodes_used   = 1;
            syms_used    = 1;
            pats_done    = 0;
            build_cursor = '0;
            build_failed = 1'b0;
            build_code   = ST_DONE;
            walk_node    = '0;
            walk_dead    = 1'b0;
        endfunction

        function t_status give_up(t_status code);
            build_failed = 1'b1;
            build_code   = code;
            return code;
        endfunction

        // Insert one pattern byte; byte 0 closes the pattern with an accept entry
        function t_status grow_trie(t_char c);
            t_sym s;
            int   slot;
            if (build_failed) return build_code;
            if (c == '0) begin
                if (pats_done >= MAX_PATTERNS) return give_up(ST_TOO_MANY);
                slot = int'(build_cursor) * MAX_SYMBOLS;
                edge_tab[slot] = '{valid: 1'b1, accept: 1'b1, data: EDATA_W'(pats_done)};
                pats_done++;
                build_cursor = '0;
                return ST_DONE;
            end
            s = sym_of_byte[c];
            if (s == '0) begin
                if (syms_used >= MAX_SYMBOLS) return give_up(ST_ALPHABET_FULL);
                s = SYM_W'(syms_used);
                syms_used++;
                sym_of_byte[c] = s;
            end
            slot = int'(build_cursor) * MAX_SYMBOLS + int'(s);
            if (edge_tab[slot].valid && !edge_tab[slot].accept) begin
                build_cursor = t_node'(edge_tab[slot].data);
                return ST_DONE;
            end
            if (nodes_used >= MAX_NODES) return give_up(ST_TABLE_FULL);
            edge_tab[slot] = '{valid: 1'b1, accept: 1'b0, data: EDATA_W'(nodes_used)};
            build_cursor = t_node'(nodes_used);
            nodes_used++;
            return ST_DONE;
        endfunction

        // Advance the text walk by one byte
        function t_status step_walk(t_char c, logic restart, output logic [PIDX_W-1:0] idx);
            int slot;
            idx = '0;
            if (restart) begin
                walk_node = '0;
                walk_dead = 1'b0;
            end
            if (walk_dead) return ST_REJECTED;
            slot = int'(walk_node) * MAX_SYMBOLS + int'(sym_of_byte[c]);
            if (!edge_tab[slot].valid) begin
                walk_dead = 1'b1;
                return ST_REJECTED;
            end
            if (edge_tab[slot].accept) begin
                idx = edge_tab[slot].data[PIDX_W-1:0];
                walk_dead = 1'b1;
                return ST_MATCHED;
            end
            walk_node = t_node'(edge_tab[slot].data);
            return ST_RUNNING;
        endfunction

        function void take_item(t_kind kind, t_char c, logic restart);
            trie_result_t      r;
            logic [PIDX_W-1:0] idx;
            r.status = ST_DONE;
            idx      = '0;
            case (kind)
                KIND_CLEAR:  wipe();
                KIND_INSERT: r.status = grow_trie(c);
                KIND_MATCH:  r.status = step_walk(c, restart, idx);
                default: ;
            endcase
            r.pattern_index = (r.status == ST_MATCHED) ? idx : '0;
            r.node_count    = NCOUNT_W'(nodes_used);
            awaited_results.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [PIDX_W-1:0] pi,
                                   logic [NCOUNT_W-1:0] nc);
            trie_result_t e;
            results_seen++;
            if (awaited_results.size() == 0) begin
                if (mismatches < 10)
                    $display({"ERROR: result %0d arrived with no item pending: ",
                              "status %0d index %0d nodes %0d"},
                             results_seen, st, pi, nc);
                mismatches++;
                return;
            end
            e = awaited_results.pop_front();
            if (st !== e.status || pi !== e.pattern_index || nc !== e.node_count) begin
                if (mismatches < 10)
                    $display({"ERROR: result %0d: expected status %0d index %0d nodes %0d, ",
                              "got status %0d index %0d nodes %0d"},
                             results_seen, e.status, e.pattern_index, e.node_count,
                             st, pi, nc);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    tkm_in_if  in_ch ();
    tkm_out_if res_ch ();

    trie_keyword_matcher i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    trie_shadow board;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int recv_hold     = 0;
    int cycle_count   = 0;
    int items_sent    = 0;
    int clears_sent   = 0;

    // Keywords of the current build, kept so that text can follow real paths
    logic [7:0] word_b [WORD_SLOTS][WORD_MAX];
    int         word_len [WORD_SLOTS];
    int         word_cnt;
    logic [7:0] alpha [MAX_SYMBOLS];
    int         alpha_n;

    always #1 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles, %0d results still pending",
                     cycle_count, board.awaited_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Check every result the moment it is taken
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            board.check_result(res_ch.status, res_ch.pattern_index, res_ch.node_count);
    end

    // Result side: random stalls, plus a long hold-off counted down here
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (recv_hold > 0) begin
                res_ch.ready <= 1'b0;
                recv_hold--;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Offer one item from a falling edge and hold it until taken. Valid stays
    // high afterwards so back-to-back items need no extra assignment.
    task automatic send_item(t_kind kind, t_char c, logic restart);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.character <= c;
        in_ch.restart   <= restart;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        board.take_item(kind, c, restart);
        items_sent++;
        if (kind == KIND_CLEAR) clears_sent++;
        @(negedge i_clk);
    endtask

    // Empty the trie; the block sweeps its table before it takes more items
    task automatic clear_trie();
        send_item(KIND_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
        word_cnt = 0;
        alpha_n  = 0;
    endtask

    task automatic pick_alphabet(int n);
        logic [7:0] b;
        bit         dup;
        alpha_n = 0;
        while (alpha_n < n) begin
            b   = 8'($urandom_range(1, 255));
            dup = 1'b0;
            for (int i = 0; i < alpha_n; i++)
                if (alpha[i] == b) dup = 1'b1;
            if (!dup) begin
                alpha[alpha_n] = b;
                alpha_n++;
            end
        end
    endtask

    task automatic make_word(int len);
        if (word_cnt >= WORD_SLOTS) return;
        word_len[word_cnt] = len;
        for (int i = 0; i < len; i++)
            word_b[word_cnt][i] = alpha[$urandom_range(alpha_n - 1)];
        word_cnt++;
    endtask

    // Byte that maps to the delimiter: zero, or any byte with no symbol yet
    function automatic logic [7:0] delim_byte();
        logic [7:0] b;
        if ($urandom_range(1) == 0) return 8'h00;
        for (int k = 0; k < 20; k++) begin
            b = 8'($urandom_range(255));
            if (board.sym_of_byte[b] == '0) return b;
        end
        return 8'h00;
    endfunction

    task automatic insert_word(int w, bit finish);
        for (int i = 0; i < word_len[w]; i++)
            send_item(KIND_INSERT, word_b[w][i], 1'($urandom_range(1)));
        if (finish) send_item(KIND_INSERT, 8'h00, 1'($urandom_range(1)));
    endtask

    // Walk a keyword as text; optionally corrupt one byte or leave it unclosed
    task automatic match_word(int w, bit from_root, bit mutate, bit close);
        int         mut_pos;
        logic [7:0] b;
        mut_pos = (mutate && word_len[w] > 0) ? $urandom_range(word_len[w] - 1) : -1;
        for (int i = 0; i < word_len[w]; i++) begin
            b = (i == mut_pos) ? 8'($urandom_range(255)) : word_b[w][i];
            send_item(KIND_MATCH, b, (i == 0) ? from_root : 1'b0);
        end
        if (close || word_len[w] == 0)
            send_item(KIND_MATCH, delim_byte(), (word_len[w] == 0) ? from_root : 1'b0);
    endtask

    // Edges and special cases on a freshly reset trie
    task automatic run_directed();
        send_item(KIND_UNUSED, 8'hFF, 1'b1);   // ignored kind
        send_item(KIND_MATCH,  8'h00, 1'b1);   // empty trie: reject
        send_item(KIND_MATCH,  8'h41, 1'b0);   // dead token stays rejected
        send_item(KIND_INSERT, 8'h00, 1'b0);   // empty pattern on the root
        send_item(KIND_MATCH,  8'h00, 1'b1);   // matches the empty pattern
        send_item(KIND_MATCH,  8'h41, 1'b0);   // token is over after a match
        send_item(KIND_INSERT, 8'hFF, 1'b0);
        send_item(KIND_INSERT, 8'h01, 1'b0);
        send_item(KIND_INSERT, 8'h00, 1'b1);
        send_item(KIND_INSERT, 8'hFF, 1'b1);   // duplicate: later index wins
        send_item(KIND_INSERT, 8'h01, 1'b0);
        send_item(KIND_INSERT, 8'h00, 1'b0);
        send_item(KIND_MATCH,  8'hFF, 1'b1);
        send_item(KIND_MATCH,  8'h01, 1'b0);
        send_item(KIND_MATCH,  8'h80, 1'b0);   // unseen byte closes the token
        send_item(KIND_MATCH,  8'hFF, 1'b1);
        send_item(KIND_MATCH,  8'h7E, 1'b0);   // delimiter where no pattern ends
        send_item(KIND_MATCH,  8'hFF, 1'b0);
        send_item(KIND_MATCH,  8'h55, 1'b1);   // root delimiter edge
        send_item(KIND_INSERT, 8'h80, 1'b1);   // restart has no meaning here
        send_item(KIND_INSERT, 8'h00, 1'b0);
        send_item(KIND_MATCH,  8'h80, 1'b1);
        send_item(KIND_MATCH,  8'h00, 1'b0);
        send_item(KIND_UNUSED, 8'h00, 1'b0);
    endtask

    // Fill the alphabet with a long pattern, run out of symbols inside a short one, then keep using the trie
    task automatic run_alphabet_full();
        clear_trie();
        pick_alphabet(MAX_SYMBOLS);
        word_len[0] = MAX_SYMBOLS - 1;
        for (int i = 0; i < MAX_SYMBOLS - 1; i++) word_b[0][i] = alpha[i];
        word_len[1] = 3;
        word_b[1][0] = alpha[0];
        word_b[1][1] = alpha[1];
        word_b[1][2] = alpha[MAX_SYMBOLS - 1];
        word_cnt = 2;
        insert_word(0, 1'b1);
        insert_word(1, 1'b1);
        repeat (3) send_item(KIND_INSERT, 8'($urandom_range(255)), 1'($urandom_range(1)));
        match_word(0, 1'b1, 1'b0, 1'b1);
        match_word(1, 1'b1, 1'b0, 1'b1);
        match_word(0, 1'b1, 1'b1, 1'b1);
    endtask

    // Four long chains with distinct first bytes exhaust the node store
    task automatic run_table_full();
        clear_trie();
        pick_alphabet(8);
        for (int k = 0; k < 4; k++) begin
            word_len[k]  = 70;
            word_b[k][0] = alpha[k];
            for (int i = 1; i < 70; i++) word_b[k][i] = alpha[4 + $urandom_range(3)];
        end
        word_cnt = 4;
        for (int k = 0; k < 4; k++) insert_word(k, 1'b1);
        repeat (3) send_item(KIND_INSERT, 8'($urandom_range(255)), 1'($urandom_range(1)));
        for (int k = 0; k < 4; k++) match_word(k, 1'b1, 1'b0, 1'b1);
    endtask

    // More pattern ends than slots; duplicates come naturally from the tiny alphabet
    task automatic run_too_many();
        clear_trie();
        pick_alphabet(4);
        repeat (MAX_PATTERNS + 2) begin
            make_word($urandom_range(0, 2));
            insert_word(word_cnt - 1, 1'b1);
        end
        repeat (25) match_word($urandom_range(word_cnt - 1), 1'b1, $urandom_range(5) == 0, 1'b1);
    endtask

    // Random build, then mostly keyword text with noise and broken sequences
    task automatic run_mix(int budget, bit squeeze);
        int act;
        int stop_at;
        clear_trie();
        pick_alphabet($urandom_range(2, 20));
        repeat ($urandom_range(5, 25)) begin
            make_word($urandom_range(0, 6));
            insert_word(word_cnt - 1, 1'b1);
        end
        // long hold on the result side while items keep coming
        if (squeeze) recv_hold = HOLD_CYCLES;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            act = $urandom_range(99);
            if (act < 65) begin
                match_word($urandom_range(word_cnt - 1), $urandom_range(9) != 0,
                           $urandom_range(9) == 0, $urandom_range(9) != 0);
            end else if (act < 75) begin
                if (word_cnt < 60) begin
                    make_word($urandom_range(0, 6));
                    insert_word(word_cnt - 1, $urandom_range(7) != 0);
                end
            end else if (act < 80) begin
                insert_word($urandom_range(word_cnt - 1), 1'b1);
            end else if (act < 95) begin
                send_item(KIND_MATCH, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end else if (act < 98) begin
                send_item(KIND_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end else begin
                send_item(KIND_INSERT, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        board = new();
        in_ch.valid     = 1'b0;
        in_ch.kind      = KIND_CLEAR;
        in_ch.character = 8'h00;
        in_ch.restart   = 1'b0;
        i_rst_n         = 1'b0;
        word_cnt        = 0;
        alpha_n         = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // no idling on either side
        send_idle_pct = 0;
        stall_pct     = 0;
        run_directed();
        run_alphabet_full();
        run_mix(170, 1'b1);

        // sender mostly idle
        send_idle_pct = 68;
        stall_pct     = 0;
        run_table_full();
        run_mix(170, 1'b0);

        // receiver mostly stalling
        send_idle_pct = 0;
        stall_pct     = 68;
        run_too_many();
        run_mix(170, 1'b0);

        // both sides idle part of the time
        send_idle_pct = 32;
        stall_pct     = 32;
        run_mix(170, 1'b0);

        // drain: release the result side and let the pipe empty
        in_ch.valid <= 1'b0;
        stall_pct    = 0;
        while (board.awaited_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run covered %0d items (%0d clears) and %0d checked results %s",
                 items_sent, clears_sent, board.results_seen, "over four idle/stall mixes,");
        $display("including symbol, node and pattern-slot exhaustion and a long result-side hold.");
        if (board.mismatches == 0 && board.awaited_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("ERROR: %0d bad results, %0d results never arrived",
                     board.mismatches, board.awaited_results.size());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/tkm_pkg.sv
sv/tkm_in_if.sv
sv/tkm_out_if.sv
sv/tkm_ram.sv
sv/tkm_lookup.sv
sv/tkm_trie.sv
sv/trie_keyword_matcher.sv
sim/tb_trie_keyword_matcher.sv
